>>> design/edfs_pkg.sv
// Shared types and constants for the EDF periodic task scheduler.
`timescale 1ns / 1ps

package edfs_pkg;

  localparam int NUM_TASKS_DEF = 4;   // default number of task slots
  localparam int TASK_WORDS    = 4;   // task words in the register map
  localparam int WORD_W        = 48;  // task word width
  localparam int FIELD_W       = 16;  // capacity, period, relative deadline
  localparam int DL_W          = 17;  // deadline countdown width
  localparam int CNT_W         = 3;   // active task count width
  localparam int CFG_IDX_W     = 3;   // configuration register index width
  localparam int OUT_IDX_W     = 2;   // result task index width
  localparam int TW_IDX_W      = 2;   // task word select width

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_WORD_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_WORD_3  = 3'd4;

  // Per-task dynamic state
  typedef struct packed {
    logic [FIELD_W-1:0] work;
    logic [FIELD_W-1:0] rel;
    logic [DL_W-1:0]    dl;
  } task_state_t;

  // Control from the sequencer to the task unit
  typedef struct packed {
    logic            restart;
    logic            active;
    logic            found;
    logic [DL_W-1:0] best;
  } alu_ctl_t;

  // Selection result from the task unit
  typedef struct packed {
    logic               take;
    logic [DL_W-1:0]    cand_dl;
    logic [FIELD_W-1:0] cand_work;
  } alu_res_t;

endpackage

>>> design/edfs_ifs.sv
// Valid/ready channel interfaces for the EDF scheduler ports.
`timescale 1ns / 1ps

interface edfs_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface edfs_out_if;
  logic       valid;
  logic       ready;
  logic       busy_res;
  logic [1:0] task_index;

  modport source (output valid, output busy_res, output task_index, input ready);
  modport sink   (input valid, input busy_res, input task_index, output ready);
endinterface

interface edfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  idx;
  logic [47:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

>>> design/edfs_task_alu.sv
// Shared per-task unit: release, deadline compare and countdown update for one task.
`timescale 1ns / 1ps

module edfs_task_alu
  import edfs_pkg::*;
(
  input  alu_ctl_t           ctl,
  input  logic [WORD_W-1:0]  word,
  input  task_state_t        cur,
  output task_state_t        upd,
  output alu_res_t           res
);

  task_state_t        base;
  task_state_t        rls;
  logic [FIELD_W-1:0] per;

  always_comb begin
    // drop all state on restart
    base = ctl.restart ? '0 : cur;

    per = word[2*FIELD_W-1:FIELD_W];
    if (per == '0) begin
      per = FIELD_W'(1);
    end

    rls = base;
    if (ctl.active && base.rel == '0) begin
      rls.work = word[FIELD_W-1:0];
      rls.rel  = per;
      rls.dl   = {1'b0, word[3*FIELD_W-1:2*FIELD_W]};
    end

    res.cand_dl   = rls.dl;
    res.cand_work = rls.work;
    res.take      = ctl.active && (rls.work != '0) && (!ctl.found || rls.dl < ctl.best);

    // advance countdowns, saturating at zero
    upd = rls;
    if (ctl.active) begin
      if (rls.rel != '0) begin
        upd.rel = rls.rel - 1'b1;
      end
      if (rls.dl != '0) begin
        upd.dl = rls.dl - 1'b1;
      end
    end
  end

endmodule

>>> design/edf_periodic_task_scheduler_core.sv
// Top level of the earliest-deadline-first periodic task scheduler.
`timescale 1ns / 1ps

// Each input beat is one scheduler tick and yields exactly one result beat naming the task
// that runs for that tick (busy_res = 1, task_index) or an idle tick (busy_res = 0,
// task_index = 0). On a tick, every active task whose release countdown has reached zero
// is reloaded from its task word (capacity as remaining work, period with zero read as
// one, relative deadline); among active tasks with work left the one with the smallest
// deadline countdown runs one unit, the lowest index winning ties; release and deadline
// countdowns then fall by one and stop at zero. restart = 1 clears all task state first,
// so every active task releases on that tick. Tasks in use are indices 0 up to
// active_count - 1, limited to NUM_TASKS and to the four task words. A tick occupies the
// block through the accept cycle, a scan of one task slot per cycle through the single
// shared task unit, and a finishing cycle that charges the chosen task and loads the
// output register. in_ch.ready is high only between ticks; a finished result waits in
// the output register while the next tick is accepted, and the finishing cycle stalls
// only when the previous result has not yet been taken.
// Configuration writes are taken in any cycle (cfg_ch.ready is tied high) and must only
// be issued between ticks; writes to indexes beyond the register map are dropped.

module edf_periodic_task_scheduler_core
  import edfs_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  edfs_in_if.sink           in_ch,
  edfs_out_if.source        out_ch,
  edfs_cfg_if.sink          cfg_ch
);

  localparam int TIDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Configuration registers
  logic [CNT_W-1:0]   active_count_r;
  logic [WORD_W-1:0]  task_word_r [TASK_WORDS];

  // Task state, one entry per slot
  task_state_t        task_st_r [NUM_TASKS];

  // Sequencer
  state_t             state_r;
  logic [TIDX_W-1:0]  scan_r;
  logic               restart_r;
  logic               found_r;
  logic [DL_W-1:0]    best_r;
  logic [TIDX_W-1:0]  pick_r;
  logic [FIELD_W-1:0] best_work_r;

  // Output register
  logic                 out_valid_r;
  logic                 out_busy_r;
  logic [OUT_IDX_W-1:0] out_idx_r;

  logic [CNT_W-1:0]   live;
  alu_ctl_t           alu_ctl;
  task_state_t        alu_upd;
  alu_res_t           alu_res;
  logic               in_beat;
  logic               out_free;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.busy_res   = out_busy_r;
  assign out_ch.task_index = out_idx_r;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Number of live tasks: register value limited by slots and task words
  always_comb begin
    live = active_count_r;
    if (live > CNT_W'(NUM_TASKS)) begin
      live = CNT_W'(NUM_TASKS);
    end
    if (live > CNT_W'(TASK_WORDS)) begin
      live = CNT_W'(TASK_WORDS);
    end
  end

  always_comb begin
    alu_ctl.restart = restart_r;
    alu_ctl.active  = (CNT_W'(scan_r) < live);
    alu_ctl.found   = found_r;
    alu_ctl.best    = best_r;
  end

  // One task slot per cycle goes through the shared unit
  edfs_task_alu u_alu (
    .ctl  (alu_ctl),
    .word (task_word_r[TW_IDX_W'(scan_r)]),
    .cur  (task_st_r[scan_r]),
    .upd  (alu_upd),
    .res  (alu_res)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= '0;
      for (int i = 0; i < TASK_WORDS; i++) begin
        task_word_r[i] <= '0;
      end
    end else if (cfg_ch.valid) begin
      if (cfg_ch.idx == CFG_ACTIVE_COUNT) begin
        active_count_r <= cfg_ch.data[CNT_W-1:0];
      end else if (cfg_ch.idx >= CFG_TASK_WORD_0 && cfg_ch.idx <= CFG_TASK_WORD_3) begin
        task_word_r[TW_IDX_W'(cfg_ch.idx - CFG_TASK_WORD_0)] <= cfg_ch.data;
      end
    end
  end

  // Sequencer, task state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        task_st_r[i] <= '0;
      end
    end else begin
      // drop the beat once taken; the finishing cycle loads the next one itself
      if (out_valid_r && out_ch.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            restart_r <= in_ch.restart;
            found_r   <= 1'b0;
            best_r    <= '0;
            pick_r    <= '0;
            scan_r    <= '0;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          task_st_r[scan_r] <= alu_upd;
          if (alu_res.take) begin
            found_r     <= 1'b1;
            best_r      <= alu_res.cand_dl;
            best_work_r <= alu_res.cand_work;
            pick_r      <= scan_r;
          end
          if (scan_r == TIDX_W'(NUM_TASKS - 1)) begin
            state_r <= ST_DONE;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_DONE: begin
          // hold until the output register can take the result
          if (out_free) begin
            if (found_r) begin
              task_st_r[pick_r].work <= best_work_r - 1'b1;
            end
            out_valid_r <= 1'b1;
            out_busy_r  <= found_r;
            out_idx_r   <= found_r ? OUT_IDX_W'(pick_r) : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted tick always starts a scan at slot zero
  a_beat_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == ST_SCAN && scan_r == '0))
    else $error("tick accepted without starting a scan");

  // The scan never runs past the last task slot
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r <= TIDX_W'(NUM_TASKS - 1)))
    else $error("scan index beyond last slot");

  // A chosen task always has work left to charge
  a_pick_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && found_r) |-> (best_work_r != '0 && CNT_W'(pick_r) < live))
    else $error("chosen task has no work or is not live");

  // Idle results carry task index zero
  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_busy_r) |-> (out_idx_r == '0))
    else $error("idle result with nonzero task index");

  // A result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && state_r == ST_DONE) |=> (state_r == ST_DONE))
    else $error("result loaded over a pending beat");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the EDF periodic task scheduler core.
`timescale 1ns / 1ps

module tb_top;
  import edfs_pkg::*;

  localparam int NT            = NUM_TASKS_DEF;
  localparam int RAND_TICKS    = 1850;     // random ticks after the directed table
  localparam int CALM_TICKS    = 150;      // closing stretch with no idling
  localparam int HOLD_CYCLES   = 200;      // long receiver hold-off
  localparam int SETTLE_CYCLES = NT + 6;   // tick latency plus margin
  localparam int TIMEOUT_NS    = 5_000_000;

  // Register indexes past the end of the map; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_TASK_WORD_3 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

  typedef struct packed {
    logic                 busy;
    logic [OUT_IDX_W-1:0] idx;
  } pick_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    data;
    logic                 restart;
    bit                   pinned;
    pick_t                want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  edfs_in_if  in_ch ();
  edfs_out_if out_ch ();
  edfs_cfg_if cfg_ch ();

  edf_periodic_task_scheduler_core #(.NUM_TASKS(NT)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 8 ns clock: high 4, low 4.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the scheduler: configuration and per-task countdowns.
  logic [CNT_W-1:0]   sh_count;
  logic [WORD_W-1:0]  sh_word [TASK_WORDS];
  logic [FIELD_W-1:0] sh_work [NT];
  logic [FIELD_W-1:0] sh_rel  [NT];
  logic [DL_W-1:0]    sh_dl   [NT];

  pick_t pending_picks [$];   // expected result beats, oldest first
  stim_row_t plan [$];        // directed stimulus table

  // Sideband that travels with each input beat: a typed-in expectation, if any.
  logic  pin_en;
  pick_t pin_want;

  int  mismatches = 0;
  int  ticks_in   = 0;
  int  beats_out  = 0;
  int  busy_beats = 0;
  int  phases     = 0;
  int  idle_pct   = 0;
  bit  calm       = 1'b0;
  logic hold_req  = 1'b0;
  bit  hold_done  = 1'b0;
  bit  tick_open  = 1'b0;
  bit  cfg_open   = 1'b0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  function automatic logic [WORD_W-1:0] pack_task(input int cap, input int per, input int dl);
    logic [FIELD_W-1:0] c, p, d;
    c = cap[FIELD_W-1:0];
    p = per[FIELD_W-1:0];
    d = dl[FIELD_W-1:0];
    return {d, p, c};
  endfunction

  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [WORD_W-1:0] data);
    if (idx == CFG_ACTIVE_COUNT)
      sh_count = data[CNT_W-1:0];
    else if (idx >= CFG_TASK_WORD_0 && idx <= CFG_TASK_WORD_3)
      sh_word[TW_IDX_W'(idx - CFG_TASK_WORD_0)] = data;
  endfunction

  // One scheduler tick on the shadow state: release, pick, charge, count down.
  function automatic pick_t sched_tick(input logic restart);
    int                 live;
    int                 k;
    int                 pick;
    bit                 found;
    logic [DL_W-1:0]    best;
    logic [FIELD_W-1:0] per;
    pick_t              r;
    live  = sh_count;
    if (live > NT) live = NT;
    if (live > TASK_WORDS) live = TASK_WORDS;
    found = 1'b0;
    pick  = 0;
    best  = '0;
    if (restart) begin
      for (k = 0; k < NT; k++) begin
        sh_work[k] = '0;
        sh_rel[k]  = '0;
        sh_dl[k]   = '0;
      end
    end
    for (k = 0; k < live; k++) begin
      if (sh_rel[k] == '0) begin
        per = sh_word[k][2*FIELD_W-1:FIELD_W];
        if (per == '0) per = FIELD_W'(1);
        sh_work[k] = sh_word[k][FIELD_W-1:0];
        sh_rel[k]  = per;
        sh_dl[k]   = {1'b0, sh_word[k][3*FIELD_W-1:2*FIELD_W]};
      end
    end
    // Earliest deadline wins; strict compare keeps the lowest index on ties.
    for (k = 0; k < live; k++) begin
      if (sh_work[k] != '0 && (!found || sh_dl[k] < best)) begin
        found = 1'b1;
        best  = sh_dl[k];
        pick  = k;
      end
    end
    if (found) sh_work[pick] = sh_work[pick] - 1'b1;
    for (k = 0; k < live; k++) begin
      if (sh_rel[k] != '0) sh_rel[k] = sh_rel[k] - 1'b1;
      if (sh_dl[k] != '0)  sh_dl[k]  = sh_dl[k] - 1'b1;
    end
    r.busy = found;
    r.idx  = found ? pick[OUT_IDX_W-1:0] : '0;
    return r;
  endfunction

  // Scoreboard: check result beats first, then take config and input beats in order.
  always @(posedge clk) begin : scoreboard
    pick_t got;
    pick_t want;
    pick_t pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.busy = out_ch.busy_res;
        got.idx  = out_ch.task_index;
        beats_out++;
        if (got.busy === 1'b1) busy_beats++;
        if (pending_picks.size() == 0) begin
          flag_mismatch("result beat with nothing pending", got, 0);
        end else begin
          want = pending_picks.pop_front();
          if (got.busy !== want.busy) flag_mismatch("busy_res", got.busy, want.busy);
          if (got.idx !== want.idx)   flag_mismatch("task_index", got.idx, want.idx);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) shadow_write(cfg_ch.idx, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        ticks_in++;
        pred = sched_tick(in_ch.restart);
        // A typed-in row overrides the prediction; the shadow still advances.
        pending_picks.push_back(pin_en ? pin_want : pred);
      end
    end
  end

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WORD_W-1:0] data);
    stim_row_t r;
    r.kind = ROW_CFG;  r.idx = idx;  r.data = data;
    r.restart = 1'b0;  r.pinned = 1'b0;  r.want = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_tick(input logic restart);
    stim_row_t r;
    r.kind = ROW_TICK;  r.idx = '0;  r.data = '0;
    r.restart = restart;  r.pinned = 1'b0;  r.want = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_pinned(input logic restart, input logic busy,
                                     input logic [OUT_IDX_W-1:0] idx);
    stim_row_t r;
    r.kind = ROW_TICK;  r.idx = '0;  r.data = '0;
    r.restart = restart;  r.pinned = 1'b1;
    r.want.busy = busy;  r.want.idx = idx;
    plan.push_back(r);
  endfunction

  // Offer one tick; optionally idle first. Returns on the accepting edge, valid still high.
  task automatic send_tick(input logic restart, input bit pinned, input pick_t want);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    pin_en        <= pinned;
    pin_want      <= want;
    tick_open      = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Keep cfg valid high across back-to-back writes; close_cfg drops it.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    cfg_open      = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic close_cfg();
    if (cfg_open) begin
      cfg_ch.valid <= 1'b0;
      cfg_open      = 1'b0;
    end
  endtask

  // Drop input valid, let every pending result drain, then wait out the tick latency.
  task automatic settle();
    if (tick_open) begin
      in_ch.valid <= 1'b0;
      tick_open    = 1'b0;
    end
    @(posedge clk);
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random task word: mostly short periods so releases, overwrites and misses happen often.
  function automatic logic [WORD_W-1:0] rand_task_word();
    int per;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return WORD_W'({$urandom, $urandom});
    per = $urandom_range(0, 10);
    return pack_task($urandom_range(0, per + 1), per, $urandom_range(0, per + 4));
  endfunction

  initial begin : driver
    int    i;
    int    k;
    int    len;
    int    rand_sent;
    logic  rst_bit;
    pick_t none;
    none = '0;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.idx    <= '0;
    cfg_ch.data   <= '0;
    pin_en        <= 1'b0;
    pin_want      <= '0;
    sh_count       = '0;
    for (k = 0; k < TASK_WORDS; k++) sh_word[k] = '0;
    for (k = 0; k < NT; k++) begin
      sh_work[k] = '0;
      sh_rel[k]  = '0;
      sh_dl[k]   = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Nothing is active after reset, so the first tick idles.
    add_pinned(1'b0, 1'b0, 2'd0);
    // One task: capacity 2, period 4, deadline 3 -> run, run, idle, idle, release again.
    add_cfg(CFG_ACTIVE_COUNT, 48'd1);
    add_cfg(CFG_TASK_WORD_0, pack_task(2, 4, 3));
    add_pinned(1'b0, 1'b1, 2'd0);
    add_pinned(1'b0, 1'b1, 2'd0);
    add_pinned(1'b0, 1'b0, 2'd0);
    add_pinned(1'b0, 1'b0, 2'd0);
    add_pinned(1'b0, 1'b1, 2'd0);
    // Zero period, zero capacity, all-ones word, count above the task limit.
    add_cfg(CFG_TASK_WORD_0 + 3'd1, pack_task(1, 0, 16'hFFFF));
    add_cfg(CFG_TASK_WORD_0 + 3'd2, pack_task(0, 2, 0));
    add_cfg(CFG_TASK_WORD_3, WORD_ONES);
    add_cfg(CFG_ACTIVE_COUNT, 48'd7);
    add_pinned(1'b1, 1'b1, 2'd0);
    for (i = 0; i < 6; i++) add_tick(1'b0);
    // Missed deadlines: both saturate at zero, lowest index wins the tie.
    add_cfg(CFG_TASK_WORD_0, pack_task(16'hFFFF, 8, 0));
    add_cfg(CFG_TASK_WORD_0 + 3'd1, pack_task(5, 0, 0));
    add_pinned(1'b1, 1'b1, 2'd0);
    for (i = 0; i < 4; i++) add_tick(1'b0);
    // Unmapped indexes must not disturb the count or the words.
    add_cfg(CFG_UNMAPPED_LO, WORD_ONES);
    add_cfg(CFG_UNMAPPED_HI, WORD_ONES);
    add_cfg(CFG_ACTIVE_COUNT, 48'd0);
    add_pinned(1'b0, 1'b0, 2'd0);
    add_cfg(CFG_ACTIVE_COUNT, 48'd2);
    add_cfg(CFG_TASK_WORD_0, pack_task(3, 5, 4));
    add_cfg(CFG_TASK_WORD_0 + 3'd1, pack_task(2, 3, 2));
    add_pinned(1'b1, 1'b1, 2'd1);
    for (i = 0; i < 3; i++) add_tick(1'b0);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        if (tick_open) settle();
        cfg_write(plan[r].idx, plan[r].data);
      end else begin
        close_cfg();
        send_tick(plan[r].restart, plan[r].pinned, plan[r].want);
      end
    end

    // Random phases: reprogram while idle, then a restart and a run of ticks.
    rand_sent = 0;
    while (rand_sent < RAND_TICKS) begin
      settle();
      calm     = (rand_sent >= RAND_TICKS - CALM_TICKS);
      idle_pct = calm ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(8, 30));
      if (phases == 0) begin
        // Extreme: every word zero, full count.
        cfg_write(CFG_ACTIVE_COUNT, 48'd4);
        for (k = 0; k < TASK_WORDS; k++) cfg_write(CFG_IDX_W'(CFG_TASK_WORD_0 + k), '0);
      end else if (phases == 1) begin
        // Extreme: every word all ones, count above range.
        cfg_write(CFG_ACTIVE_COUNT, 48'd7);
        for (k = 0; k < TASK_WORDS; k++)
          cfg_write(CFG_IDX_W'(CFG_TASK_WORD_0 + k), WORD_ONES);
      end else begin
        if ($urandom_range(0, 9) < 7)
          cfg_write(CFG_ACTIVE_COUNT, ($urandom_range(0, 9) == 0) ?
                    $urandom_range(0, 7) : $urandom_range(1, 4));
        for (k = 0; k < TASK_WORDS; k++)
          if ($urandom_range(0, 9) < 7)
            cfg_write(CFG_IDX_W'(CFG_TASK_WORD_0 + k), rand_task_word());
        if ($urandom_range(0, 6) == 0)
          cfg_write(CFG_IDX_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)),
                    WORD_W'({$urandom, $urandom}));
      end
      close_cfg();

      len = $urandom_range(30, 100);
      for (i = 0; i < len && rand_sent < RAND_TICKS; i++) begin
        rst_bit = (i == 0 && $urandom_range(0, 4) != 0) || $urandom_range(0, 49) == 0;
        send_tick(rst_bit, 1'b0, none);
        rand_sent++;
        // Stall the receiver once while the sender keeps offering.
        if (phases == 3 && i == 0) hold_req <= 1'b1;
      end
      phases++;
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d ticks over %0d random phases plus the directed table.",
             ticks_in, phases);
    $display("Checked %0d result beats, %0d busy; %0d mismatches.",
             beats_out, busy_beats, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none in the calm tail.
  initial begin : sink_side
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout: %0d results still pending.", pending_picks.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
design/edfs_pkg.sv
design/edfs_ifs.sv
design/edfs_task_alu.sv
design/edf_periodic_task_scheduler_core.sv
sim/tb_top.sv
